FILE: rtl/core/spc_pkg.sv
// spc_pkg: shared constants and types of the stack pop-sequence checker
// no dependencies; imported by spc_cell, spc_chain and stack_pop_sequence_checker
package spc_pkg;

   // stack depth in cells; valid range 2 .. 65536
   localparam int STACK_DEPTH = 1024;
   localparam int VALUE_W     = 10;
   localparam int CAP_W       = 11;
   localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W       = ((TOP_W > CAP_W) ? TOP_W : CAP_W) + 1;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   // shift command broadcast to every cell of the stack chain
   typedef struct packed {
      logic               push;
      logic               pop;
      logic [VALUE_W-1:0] push_value;
   } shift_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_PUSH   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

FILE: rtl/core/spc_cell.sv
// spc_cell: one stack entry of the shifting stack chain
// depends on spc_pkg (shift command type, value width)
module spc_cell (
   input  logic                         clock,
   input  spc_pkg::shift_cmd_type       cmd,
   input  logic [spc_pkg::VALUE_W-1:0]  prev_value,
   input  logic [spc_pkg::VALUE_W-1:0]  next_value,
   output logic [spc_pkg::VALUE_W-1:0]  value
);
   import spc_pkg::*;

   logic [VALUE_W-1:0] value_ff;

   // push takes the entry above, pop takes the entry below
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         value_ff <= prev_value;
      end else if (cmd.pop) begin
         value_ff <= next_value;
      end
   end

   assign value = value_ff;

endmodule

FILE: rtl/core/spc_chain.sv
// spc_chain: row of spc_cell entries forming a shift stack, cell 0 is the top
// depends on spc_pkg and spc_cell
module spc_chain (
   input  logic                         clock,
   input  spc_pkg::shift_cmd_type       cmd,
   output logic [spc_pkg::VALUE_W-1:0]  top_value
);
   import spc_pkg::*;

   logic [VALUE_W-1:0] cell_value [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [VALUE_W-1:0] prev_value;
      logic [VALUE_W-1:0] next_value;

      if (i == 0) begin : g_first
         assign prev_value = cmd.push_value;
      end else begin : g_mid_prev
         assign prev_value = cell_value[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_last
         assign next_value = cell_value[i];
      end else begin : g_mid_next
         assign next_value = cell_value[i+1];
      end

      spc_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (cell_value[i])
      );
   end

   assign top_value = cell_value[0];

endmodule

FILE: rtl/core/stack_pop_sequence_checker.sv
// stack_pop_sequence_checker: checks whether a stream of values is a legal pop
// order of a bounded stack fed 1, 2, 3, ... in order; answers on the last item.
// Rate: an item whose value was already pushed (a pop) is taken and checked
// at once; an item with a new largest value first pushes every value below it
// that was not yet pushed, one per cycle, since the stack chain shifts one
// entry per cycle, and input is held off meanwhile. An item marked last also
// registers the answer, waiting while rsp_stall holds a previous answer. The
// stack is a row of STACK_DEPTH shift cells with cell 0 on top; no clearing
// pass is needed after reset.
// depends on spc_pkg and spc_chain
module stack_pop_sequence_checker (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_wr_en,
   input  logic [spc_pkg::CAP_W-1:0]    csr_wr_data,
   // input items
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [spc_pkg::VALUE_W-1:0]  req_seq_value,
   input  logic                         req_seq_last,
   // result items
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_sequence_ok
);
   import spc_pkg::*;

   // control and bookkeeping registers
   state_type          state_ff, state_in;
   logic [TOP_W-1:0]   top_ff, top_in;
   logic [VALUE_W-1:0] max_ff, max_in;
   logic               failed_ff, failed_in;
   logic [VALUE_W-1:0] x_ff, x_in;       // next value to push
   logic [VALUE_W-1:0] v_ff, v_in;       // value of the item being worked on
   logic               last_ff, last_in;
   logic [CAP_W-1:0]   cap_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;

   shift_cmd_type      cmd;
   logic [VALUE_W-1:0] stack_top_value;

   // capacity check, done in a width that holds both top and capacity
   logic [CMP_W-1:0]   cap_ext, depth_ext, lim, top_ext, need;
   logic               accept, greater, overflow, out_free;
   logic [VALUE_W-1:0] first_push, x_next;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign cap_ext   = CMP_W'(cap_ff);
   assign depth_ext = CMP_W'(STACK_DEPTH);
   assign lim       = (cap_ext > depth_ext) ? depth_ext : cap_ext;
   assign top_ext   = CMP_W'(top_ff);
   assign need      = CMP_W'(req_seq_value) - CMP_W'(max_ff);
   assign greater   = req_seq_value > max_ff;
   assign overflow  = (top_ext > lim) || ((need + top_ext) > lim);

   assign first_push = max_ff + VALUE_W'(1);
   assign x_next     = x_ff + VALUE_W'(1);

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   always_comb begin
      state_in     = state_ff;
      top_in       = top_ff;
      max_in       = max_ff;
      failed_in    = failed_ff;
      x_in         = x_ff;
      v_in         = v_ff;
      last_in      = last_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '{push: 1'b0, pop: 1'b0, push_value: x_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               v_in     = req_seq_value;
               last_in  = req_seq_last;
               state_in = req_seq_last ? ST_FINISH : ST_IDLE;
               if (failed_ff) begin
                  // sequence already failed: value ignored
               end else if (greater) begin
                  if (overflow) begin
                     failed_in = 1'b1;
                  end else begin
                     // push max+1 .. v-1, v itself is pushed and popped at once
                     max_in = req_seq_value;
                     x_in   = first_push;
                     if (first_push < req_seq_value) begin
                        state_in = ST_PUSH;
                     end
                  end
               end else if (top_ff == '0) begin
                  // pop of an empty stack
                  failed_in = 1'b1;
               end else begin
                  cmd.pop = 1'b1;
                  top_in  = top_ff - TOP_W'(1);
                  if (stack_top_value != req_seq_value) begin
                     failed_in = 1'b1;
                  end
               end
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            top_in   = top_ff + TOP_W'(1);
            x_in     = x_next;
            if (x_next == v_ff) begin
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            // register the answer once the output is free, then clear
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = !failed_ff;
               top_in       = '0;
               max_in       = '0;
               failed_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_ff       <= '0;
         max_ff       <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         max_ff       <= max_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      v_ff      <= v_in;
      last_ff   <= last_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   // the stack itself: a row of shift cells
   spc_chain u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .top_value (stack_top_value)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sequence_ok = rsp_ok_ff;

endmodule

FILE: rtl/core/spc_checker.sv
// spc_checker: port-level checks of stack_pop_sequence_checker, with its bind
// depends on stack_pop_sequence_checker port names only
module spc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_seq_last,
   input logic rsp_valid,
   input logic rsp_stall
);

   // an answer waiting on a stall stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // no answer right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // an answer is loaded only while input is held off
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("answer appeared while input was open");

   // a non-last item never produces an answer next cycle
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_seq_last |=> !$rose(rsp_valid))
      else $error("answer for a non-last item");

   // a last item holds off the next item in the cycle after it is taken
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_seq_last |=> req_stall)
      else $error("input open right after a last item");

endmodule

bind stack_pop_sequence_checker spc_checker u_spc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_seq_last (req_seq_last),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall)
);
